FILE: rtl/lcgtps_pkg.sv
// Shared types and constants for the LCG two-point sampler.
`default_nettype none

package lcgtps_pkg;

  // Generator state and data word width
  localparam int STATE_WIDTH = 32;
  // Modulus width: one bit more, so the modulus can reach 2^STATE_WIDTH
  localparam int MOD_W       = STATE_WIDTH + 1;
  // Double-width word for the product plus increment
  localparam int WIDE_W      = 2 * STATE_WIDTH;
  // Step counter holds up to WIDE_W
  localparam int CNT_W       = $clog2(WIDE_W + 1);

  // Configuration bus
  localparam int APB_DW      = 64;
  localparam int APB_AW      = 6;
  localparam int REG_IDX_W   = 3;

  // Register reset values
  localparam logic [STATE_WIDTH-1:0] SEED_RST       = STATE_WIDTH'(1);
  localparam logic [STATE_WIDTH-1:0] MULTIPLIER_RST = STATE_WIDTH'(16807);
  localparam logic [STATE_WIDTH-1:0] INCREMENT_RST  = STATE_WIDTH'(0);
  localparam logic [MOD_W-1:0]       MODULUS_RST    = MOD_W'(64'd2147483647);
  localparam logic [STATE_WIDTH-1:0] THRESHOLD_RST  = STATE_WIDTH'(64'd1073741823);
  localparam logic [STATE_WIDTH-1:0] LOW_VALUE_RST  = STATE_WIDTH'(0);
  localparam logic [STATE_WIDTH-1:0] HIGH_VALUE_RST = STATE_WIDTH'(1);
  localparam logic [STATE_WIDTH-1:0] GEN_STATE_RST  = STATE_WIDTH'(1);

  // Register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEED       = 3'd0,
    REG_MULTIPLIER = 3'd1,
    REG_INCREMENT  = 3'd2,
    REG_MODULUS    = 3'd3,
    REG_THRESHOLD  = 3'd4,
    REG_LOW_VALUE  = 3'd5,
    REG_HIGH_VALUE = 3'd6
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [STATE_WIDTH-1:0] seed;
    logic [STATE_WIDTH-1:0] multiplier;
    logic [STATE_WIDTH-1:0] increment;
    logic [MOD_W-1:0]       modulus_eff;
    logic [STATE_WIDTH-1:0] threshold;
    logic [STATE_WIDTH-1:0] low_value;
    logic [STATE_WIDTH-1:0] high_value;
  } cfg_t;

  // Result of one restoring shift-subtract step
  typedef struct packed {
    logic [MOD_W-1:0] rem;
    logic             qbit;
  } step_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FRAC,
    ST_MULT,
    ST_ADD,
    ST_NEXT,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/lcgtps_divstep.sv
// One restoring shift-subtract step: shift a bit into the remainder, subtract if it fits.
`default_nettype none

module lcgtps_divstep
  import lcgtps_pkg::*;
(
  input  logic [MOD_W-1:0] rem,
  input  logic             din,
  input  logic [MOD_W-1:0] divisor,
  output step_res_t        res
);

  logic [MOD_W:0] shifted;
  logic [MOD_W:0] diff;
  logic           fits;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem, din};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  // Remainder stays below the divisor, so the top bit drops
  assign res.rem  = fits ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
  assign res.qbit = fits;

endmodule

`default_nettype wire

FILE: rtl/lcgtps_regs.sv
// Configuration register file with APB-style access and effective-modulus clamp.
`default_nettype none

module lcgtps_regs
  import lcgtps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [STATE_WIDTH-1:0] seed;
  logic [STATE_WIDTH-1:0] multiplier;
  logic [STATE_WIDTH-1:0] increment;
  logic [MOD_W-1:0]       modulus;
  logic [STATE_WIDTH-1:0] threshold;
  logic [STATE_WIDTH-1:0] low_value;
  logic [STATE_WIDTH-1:0] high_value;

  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;
  logic [MOD_W-1:0]       mod_top;
  logic [MOD_W-1:0]       mod_floor;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_AW-1 -: REG_IDX_W];

  // Write the addressed register; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= SEED_RST;
      multiplier <= MULTIPLIER_RST;
      increment  <= INCREMENT_RST;
      modulus    <= MODULUS_RST;
      threshold  <= THRESHOLD_RST;
      low_value  <= LOW_VALUE_RST;
      high_value <= HIGH_VALUE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED:       seed       <= pwdata[STATE_WIDTH-1:0];
        REG_MULTIPLIER: multiplier <= pwdata[STATE_WIDTH-1:0];
        REG_INCREMENT:  increment  <= pwdata[STATE_WIDTH-1:0];
        REG_MODULUS:    modulus    <= pwdata[MOD_W-1:0];
        REG_THRESHOLD:  threshold  <= pwdata[STATE_WIDTH-1:0];
        REG_LOW_VALUE:  low_value  <= pwdata[STATE_WIDTH-1:0];
        REG_HIGH_VALUE: high_value <= pwdata[STATE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_SEED:       prdata = APB_DW'(seed);
      REG_MULTIPLIER: prdata = APB_DW'(multiplier);
      REG_INCREMENT:  prdata = APB_DW'(increment);
      REG_MODULUS:    prdata = APB_DW'(modulus);
      REG_THRESHOLD:  prdata = APB_DW'(threshold);
      REG_LOW_VALUE:  prdata = APB_DW'(low_value);
      REG_HIGH_VALUE: prdata = APB_DW'(high_value);
      default:        prdata = '0;
    endcase
  end

  // Clamp the modulus into [2, 2^STATE_WIDTH]
  assign mod_top   = MOD_W'(1) << STATE_WIDTH;
  assign mod_floor = MOD_W'(2);

  always_comb begin
    cfg.seed        = seed;
    cfg.multiplier  = multiplier;
    cfg.increment   = increment;
    cfg.threshold   = threshold;
    cfg.low_value   = low_value;
    cfg.high_value  = high_value;
    if (modulus < mod_floor) begin
      cfg.modulus_eff = mod_floor;
    end else if (modulus > mod_top) begin
      cfg.modulus_eff = mod_top;
    end else begin
      cfg.modulus_eff = modulus;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcg_two_point_sampler_core.sv
// Top level: LCG with general modulus and two-point sampler, one shared divide step unit.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   request  | req_valid / req_ready  | restart
//   result   | rsp_valid / rsp_ready  | raw_state, uniform_fraction, chosen_value,
//            |                        | picked_low
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (register i at 8*i)
//
// From acceptance to result a transaction runs in order: 32 steps reduce the state
// modulo the modulus, 32 steps form the fraction, the product is formed, the increment
// is added, 64 steps reduce the product, then the result register is loaded.
// All reduction and division steps run through the single shift-subtract unit.
// Reset clears the sequencer and result valid, and loads register and state defaults.
// A waiting result sits in the output register; the next request is taken meanwhile,
// and its finish stalls only while the previous result has not been taken.
`default_nettype none

module lcg_two_point_sampler_core
  import lcgtps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // request
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   restart,
  // result
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [STATE_WIDTH-1:0] raw_state,
  output logic [STATE_WIDTH-1:0] uniform_fraction,
  output logic [STATE_WIDTH-1:0] chosen_value,
  output logic                   picked_low,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t                   cfg;
  seq_state_t             state;
  seq_state_t             state_next;

  logic [STATE_WIDTH-1:0] gstate;
  logic [STATE_WIDTH-1:0] cur;
  logic [STATE_WIDTH-1:0] quot;
  logic [MOD_W-1:0]       m;
  logic [MOD_W-1:0]       rem;
  logic [WIDE_W-1:0]      div;
  logic [WIDE_W-1:0]      prod;
  logic [CNT_W-1:0]       cnt;
  step_res_t              step;

  logic                   last_step;
  logic                   out_free;
  logic                   accept;

  lcgtps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared shift-subtract unit
  lcgtps_divstep u_step (
    .rem     (rem),
    .din     (div[WIDE_W-1]),
    .divisor (m),
    .res     (step)
  );

  assign last_step = (cnt == CNT_W'(1));
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_REDUCE;
      ST_REDUCE: if (last_step) state_next = ST_FRAC;
      ST_FRAC:   if (last_step) state_next = ST_MULT;
      ST_MULT:   state_next = ST_ADD;
      ST_ADD:    state_next = ST_NEXT;
      ST_NEXT:   if (last_step) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath: operands, shared unit feedback, product
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // Load the value to reduce: seed on restart, else the stored state
        div <= {(restart ? cfg.seed : gstate), STATE_WIDTH'(0)};
        rem <= '0;
        cnt <= CNT_W'(STATE_WIDTH);
        m   <= cfg.modulus_eff;
      end
      ST_REDUCE: begin
        rem <= step.rem;
        if (last_step) begin
          cur <= step.rem[STATE_WIDTH-1:0];
          div <= '0;
          cnt <= CNT_W'(STATE_WIDTH);
        end else begin
          div <= div << 1;
          cnt <= cnt - CNT_W'(1);
        end
      end
      ST_FRAC: begin
        // Quotient bits of (cur * 2^STATE_WIDTH) / m
        rem  <= step.rem;
        quot <= {quot[STATE_WIDTH-2:0], step.qbit};
        cnt  <= cnt - CNT_W'(1);
      end
      ST_MULT: begin
        prod <= WIDE_W'(cfg.multiplier) * WIDE_W'(cur);
      end
      ST_ADD: begin
        div <= prod + WIDE_W'(cfg.increment);
        rem <= '0;
        cnt <= CNT_W'(WIDE_W);
      end
      ST_NEXT: begin
        rem <= step.rem;
        div <= div << 1;
        cnt <= cnt - CNT_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Generator state: advance at the last reduction step of the product
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= GEN_STATE_RST;
    end else if (state == ST_NEXT && last_step) begin
      gstate <= step.rem[STATE_WIDTH-1:0];
    end
  end

  // Result register: load when free, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      raw_state        <= cur;
      uniform_fraction <= quot;
      picked_low       <= (cur <= cfg.threshold);
      chosen_value     <= (cur <= cfg.threshold) ? cfg.low_value : cfg.high_value;
    end
  end

`ifndef SYNTHESIS
  // Remainder of the shared unit stays below the divisor while it works
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE || state == ST_FRAC || state == ST_NEXT) |-> (rem < m))
    else $error("remainder not below modulus");

  // Step counter never runs out inside a division sweep
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE || state == ST_FRAC || state == ST_NEXT) |-> (cnt != '0))
    else $error("step counter empty during sweep");

  // Advanced state is reduced below the modulus
  a_gstate_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> ({1'b0, gstate} < m))
    else $error("generator state not reduced");

  // An accepted request always enters the reduction sweep
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_REDUCE))
    else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire
